FILE: rtl/assert_macros.svh
// Assertion macros shared by the stream find-and-replace RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define SFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checks that a condition in one cycle is followed by another in the next.
`define SFR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/sfr_pkg.sv
// Package for the stream find-and-replace block: payload structs, register
// indexes, and the command/status structs between controller and datapath.
// No dependencies.
package sfr_pkg;

  // Each byte-string register holds up to eight bytes.
  localparam int unsigned BYTES_MAX  = 8;
  localparam int unsigned BYTE_SEL_W = 3;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 64;

  localparam int unsigned REPL_MAX   = 8;
  localparam int unsigned REPL_CAP   = (REPL_MAX < BYTES_MAX) ? REPL_MAX : BYTES_MAX;
  localparam int unsigned REPL_IDX_W = $clog2(REPL_CAP + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 8'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                  load;
    logic                  pop;
    logic                  repl;
    logic                  marker;
    logic                  clr;
    logic                  out_last;
    logic [REPL_IDX_W-1:0] repl_idx;
  } sfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic prefix;
    logic full;
    logic count_one;
    logic repl_done;
    logic repl_final;
    logic slot_free;
  } sfr_status_t;

endpackage

FILE: rtl/sfr_datapath.sv
// Datapath of the stream find-and-replace block: configuration registers,
// pending byte buffer, match compare and the output register. Uses sfr_pkg.
module sfr_datapath import sfr_pkg::*; #(
  parameter int unsigned PatternMax = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_item_t              in_data_i,
  input  logic                  out_ready_i,
  input  sfr_cmd_t              cmd_i,
  output sfr_status_t           status_o,
  output logic                  out_valid_o,
  output out_item_t             out_data_o
);

  localparam int unsigned PatCap = (PatternMax < BYTES_MAX) ? PatternMax : BYTES_MAX;
  localparam int unsigned CntW   = $clog2(PatCap + 1);

  logic [CFG_DATA_W-1:0] pat_bytes_q, rep_bytes_q;
  logic [LEN_W-1:0]      pat_len_q, rep_len_q;

  logic [7:0]      pend_q [PatCap];
  logic [7:0]      pend_d [PatCap];
  logic [CntW-1:0] cnt_q, cnt_d;

  logic            out_vld_q, out_vld_d;
  out_item_t       out_q, out_d;

  logic [LEN_W-1:0]      plen4, rlen4;
  logic [CntW-1:0]       plen, wr_pos;
  logic [REPL_IDX_W-1:0] rlen;
  logic [7:0]            rep_byte;
  logic                  prefix, slot_free, emit, pat_write;

  // The configuration port is always ready, so a valid write is a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes_q <= '0;
      pat_len_q   <= LEN_W'(1);
      rep_bytes_q <= '0;
      rep_len_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PATTERN_BYTES:      pat_bytes_q <= cfg_data_i;
        CFG_PATTERN_LENGTH:     pat_len_q   <= cfg_data_i[LEN_W-1:0];
        CFG_REPLACEMENT_BYTES:  rep_bytes_q <= cfg_data_i;
        CFG_REPLACEMENT_LENGTH: rep_len_q   <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_write = cfg_valid_i &&
                     (cfg_index_i == CFG_PATTERN_BYTES || cfg_index_i == CFG_PATTERN_LENGTH);

  // Effective lengths: a zero pattern length counts as one, both saturate.
  assign plen4 = (pat_len_q == '0) ? LEN_W'(1) :
                 (pat_len_q > LEN_W'(PatCap)) ? LEN_W'(PatCap) : pat_len_q;
  assign plen  = plen4[CntW-1:0];
  assign rlen4 = (rep_len_q > LEN_W'(REPL_CAP)) ? LEN_W'(REPL_CAP) : rep_len_q;
  assign rlen  = rlen4[REPL_IDX_W-1:0];

  assign rep_byte = rep_bytes_q[{cmd_i.repl_idx[BYTE_SEL_W-1:0], 3'b000} +: 8];

  always_comb begin
    prefix = 1'b1;
    for (int i = 0; i < int'(PatCap); i++) begin
      if ((CntW'(i) < cnt_q) && (pend_q[i] != pat_bytes_q[8*i +: 8])) begin
        prefix = 1'b0;
      end
    end
  end

  assign wr_pos = (cnt_q >= plen) ? '0 : cnt_q;

  always_comb begin
    pend_d = pend_q;
    cnt_d  = cnt_q;
    if (pat_write) begin
      cnt_d = '0;
    end else if (cmd_i.load) begin
      for (int i = 0; i < int'(PatCap); i++) begin
        if (CntW'(i) == wr_pos) begin
          pend_d[i] = in_data_i.in_byte;
        end
      end
      cnt_d = wr_pos + CntW'(1);
    end else if (cmd_i.pop) begin
      for (int i = 0; i < int'(PatCap) - 1; i++) begin
        pend_d[i] = pend_q[i + 1];
      end
      cnt_d = cnt_q - CntW'(1);
    end else if (cmd_i.clr) begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < int'(PatCap); i++) begin
        pend_q[i] <= '0;
      end
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
    end
  end

  // Output register: a new result loads when the slot is empty or draining.
  assign slot_free = !out_vld_q || out_ready_i;
  assign emit      = cmd_i.pop || cmd_i.repl || cmd_i.marker;

  always_comb begin
    out_d           = out_q;
    out_vld_d       = out_vld_q && !out_ready_i;
    if (emit) begin
      out_vld_d          = 1'b1;
      out_d.out_byte     = cmd_i.pop ? pend_q[0] : (cmd_i.repl ? rep_byte : 8'h00);
      out_d.out_valid    = !cmd_i.marker;
      out_d.out_last     = cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign status_o.prefix     = prefix;
  assign status_o.full       = (cnt_q == plen);
  assign status_o.count_one  = (cnt_q == CntW'(1));
  assign status_o.repl_done  = (cmd_i.repl_idx == rlen);
  assign status_o.repl_final = ((cmd_i.repl_idx + REPL_IDX_W'(1)) == rlen);
  assign status_o.slot_free  = slot_free;

endmodule

FILE: rtl/sfr_ctrl.sv
// Controller of the stream find-and-replace block: sequences the scan,
// replacement, flush and end marker of one input byte. Uses sfr_pkg.
module sfr_ctrl import sfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_last_i,
  output logic        in_ready_o,
  input  sfr_status_t status_i,
  output sfr_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPL,
    ST_FLUSH,
    ST_MARK
  } state_e;

  state_e                state_q, state_d;
  logic [REPL_IDX_W-1:0] idx_q, idx_d;
  logic                  last_q, last_d;
  logic                  in_ready_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.repl_idx = idx_q;
    state_d        = state_q;
    idx_d          = idx_q;
    last_d         = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          last_d     = in_last_i;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.prefix && status_i.full) begin
          cmd_o.clr = 1'b1;
          idx_d     = '0;
          state_d   = ST_REPL;
        end else if (last_q) begin
          // Without a full match the final item sends every pending byte.
          state_d = ST_FLUSH;
        end else if (status_i.prefix) begin
          state_d = ST_IDLE;
        end else if (status_i.slot_free) begin
          cmd_o.pop = 1'b1;
        end
      end
      ST_REPL: begin
        if (status_i.repl_done) begin
          state_d = (last_q && idx_q == '0) ? ST_MARK : ST_IDLE;
        end else if (status_i.slot_free) begin
          cmd_o.repl     = 1'b1;
          cmd_o.out_last = last_q && status_i.repl_final;
          idx_d          = idx_q + REPL_IDX_W'(1);
        end
      end
      ST_FLUSH: begin
        if (status_i.slot_free) begin
          cmd_o.pop      = 1'b1;
          cmd_o.out_last = status_i.count_one;
          if (status_i.count_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_MARK: begin
        if (status_i.slot_free) begin
          cmd_o.marker   = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      last_q     <= 1'b0;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      last_q     <= last_d;
      in_ready_q <= (state_d == ST_IDLE);
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

FILE: rtl/stream_find_replace_core.sv
// Top level of the stream find-and-replace block: controller plus datapath.
// Depends on sfr_pkg, sfr_ctrl, sfr_datapath and assert_macros.svh.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_ready_o    in_data_i  (in_item_t)
//   out      output     out_valid_o / out_ready_i  out_data_o (out_item_t)
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One byte is taken at a time. A transfer on the input channel is loaded,
// each result for it is then sent in turn, and the controller decides and
// returns to idle before the next item is taken. The single output register
// receives at most one result per cycle, and a stalled output holds the
// controller in place.
// Reset clears the configuration to pattern 0 of length 1 and empty
// replacement, and empties the pending buffer; no clearing pass is needed.
`include "assert_macros.svh"

module stream_find_replace_core import sfr_pkg::*; #(
  parameter int unsigned PatternMax = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o
);

  sfr_cmd_t    cmd;
  sfr_status_t status;
  logic [2:0]  emit_vec;

  // Configuration writes must be issued only while the block is idle; the
  // block does not enforce this, and every write can be taken at once.
  assign cfg_ready_o = 1'b1;

  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.in_last),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sfr_datapath #(
    .PatternMax (PatternMax)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // The controller never asks for more than one result in a cycle, and
  // only when the output register can take it.
  assign emit_vec = {cmd.pop, cmd.repl, cmd.marker};

  `SFR_ASSERT(a_single_emit, $onehot0(emit_vec), "several results issued in a cycle")
  `SFR_ASSERT(a_emit_slot, (emit_vec != 3'b000) |-> status.slot_free, "result into full slot")
  `SFR_ASSERT(a_marker_last, out_valid_o |-> (out_data_o.out_valid || out_data_o.out_last), "bad marker")
  `SFR_ASSERT_NEXT(a_scan_after_load, in_valid_i && in_ready_o, !in_ready_o, "input taken twice")

endmodule
